// File: hdl/scs1_pkg.sv
// Shared types, key codes and character tables for the set-1 scan code translator.
// No dependencies; every other file in hdl/ imports this package.
package scs1_pkg;

    localparam int unsigned TABLE_LEN = 89;

    localparam logic [6:0] K_ALT    = 7'h38;
    localparam logic [6:0] K_CTRL   = 7'h1D;
    localparam logic [6:0] K_LSHIFT = 7'h2A;
    localparam logic [6:0] K_RSHIFT = 7'h36;
    localparam logic [6:0] K_CAPS   = 7'h3A;
    localparam logic [6:0] K_NUM    = 7'h45;
    localparam logic [6:0] K_SCROLL = 7'h46;

    localparam logic [7:0] SET_LEDS_CMD = 8'hED;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // result destination
    localparam logic TGT_CONSOLE  = 1'b0;
    localparam logic TGT_KEYBOARD = 1'b1;

    // lock_bits: bit0 scroll, bit1 num, bit2 caps
    // snap:      bit0 shift, bit1 ctrl, bit2 alt, bit3 caps
    typedef struct packed {
        logic       alt;
        logic       ctrl;
        logic       shift;
        logic [2:0] lock;
        logic [3:0] snap;
    } t_kbd_state;

    typedef struct packed {
        logic       target;
        logic [7:0] value;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] nres;
        t_result    res0;
        t_result    res1;
        t_kbd_state st;
    } t_dec_out;

    localparam logic [7:0] PLAIN_TAB [TABLE_LEN] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
        8'h00, 8'h20, 8'h00, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
        8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h00, 8'h00, 8'h92,
        8'h97, 8'h94, 8'h2D, 8'h96, 8'h35, 8'h99, 8'h2B, 8'h93,
        8'h98, 8'h95, 8'h90, 8'h91, 8'h00, 8'h00, 8'h00, 8'h8A,
        8'h8B
    };

    localparam logic [7:0] SHIFT_TAB [TABLE_LEN] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
        8'h00, 8'h20, 8'h00, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
        8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h00, 8'h00, 8'h92,
        8'h97, 8'h94, 8'h2D, 8'h96, 8'h35, 8'h99, 8'h2B, 8'h93,
        8'h98, 8'h95, 8'h90, 8'h91, 8'h00, 8'h00, 8'h00, 8'h8A,
        8'h8B
    };

    function automatic logic [7:0] plain_lookup(input logic [6:0] k);
        if (k < 7'(TABLE_LEN)) begin
            return PLAIN_TAB[k];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] shift_lookup(input logic [6:0] k);
        if (k < 7'(TABLE_LEN)) begin
            return SHIFT_TAB[k];
        end
        return 8'h00;
    endfunction

    // caps table: plain entry with letters raised to upper case
    function automatic logic [7:0] caps_lookup(input logic [6:0] k);
        logic [7:0] c;
        c = plain_lookup(k);
        if (c inside {[8'h61:8'h7A]}) begin
            c = c - CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

// File: hdl/scs1_decode.sv
// Per-code decoder: modifier/lock tracking and character selection.
// Depends on scs1_pkg (tables, key codes, state and result types).
module scs1_decode (
    input  logic [7:0]          i_code,
    input  scs1_pkg::t_kbd_state i_st,
    output scs1_pkg::t_dec_out  o_dec
);
    import scs1_pkg::*;

    logic       brk;
    logic [6:0] key;
    logic       shift_key;
    logic [7:0] p_ch;
    logic [7:0] s_ch;
    logic [7:0] c_ch;
    logic [7:0] ch;
    logic [3:0] snap_n;
    logic [2:0] lock_n;

    assign brk       = i_code[7];
    assign key       = i_code[6:0];
    assign shift_key = (key == K_LSHIFT) || (key == K_RSHIFT);
    assign p_ch      = plain_lookup(key);
    assign s_ch      = shift_lookup(key);
    assign c_ch      = caps_lookup(key);

    always_comb begin
        lock_n = i_st.lock;
        if (key == K_SCROLL) begin
            lock_n[0] = ~i_st.lock[0];
        end else if (key == K_NUM) begin
            lock_n[1] = ~i_st.lock[1];
        end else if (key == K_CAPS) begin
            lock_n[2] = ~i_st.lock[2];
        end
    end

    // snapshot reloads only on a key with a nonzero plain entry
    assign snap_n = (p_ch != 8'h00) ?
                    {i_st.lock[2], i_st.alt, i_st.ctrl, i_st.shift} : i_st.snap;

    always_comb begin
        if (!snap_n[3]) begin
            ch = snap_n[0] ? s_ch : p_ch;
        end else if (!snap_n[0]) begin
            ch = c_ch;
        end else if (s_ch != c_ch) begin
            ch = s_ch;
        end else begin
            ch = p_ch;                  // shift under caps: letters back to lower case
        end
    end

    always_comb begin
        o_dec.nres = 2'd0;
        o_dec.st   = i_st;
        o_dec.res0 = '{target: TGT_KEYBOARD, value: SET_LEDS_CMD, last: 1'b0};
        o_dec.res1 = '{target: TGT_KEYBOARD, value: {5'd0, lock_n}, last: 1'b1};
        if (brk) begin
            if (key == K_ALT) begin
                o_dec.st.alt = 1'b0;
            end else if (key == K_CTRL) begin
                o_dec.st.ctrl = 1'b0;
            end else if (shift_key) begin
                o_dec.st.shift = 1'b0;
            end
            o_dec.st.snap = {i_st.snap[3], 3'b000};
        end else if (key == K_ALT) begin
            o_dec.st.alt = 1'b1;
        end else if (key == K_CTRL) begin
            o_dec.st.ctrl = 1'b1;
        end else if (shift_key) begin
            o_dec.st.shift = 1'b1;
        end else if (key == K_SCROLL || key == K_NUM || key == K_CAPS) begin
            o_dec.st.lock = lock_n;
            o_dec.nres    = 2'd2;
        end else begin
            o_dec.st.snap = snap_n;
            o_dec.res0    = '{target: TGT_CONSOLE, value: ch, last: 1'b1};
            if (!snap_n[1] && ch != 8'h00) begin
                o_dec.nres = 2'd1;
            end
        end
    end

endmodule

// File: hdl/scs1_outq.sv
// Two-entry result queue between the decoder and the output channel.
// Depends on scs1_pkg (t_result); takes up to two results per cycle, gives one.
module scs1_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  scs1_pkg::t_result i_push0,
    input  scs1_pkg::t_result i_push1,
    input  logic              i_pop,
    output logic [1:0]        o_cnt,
    output scs1_pkg::t_result o_head
);
    import scs1_pkg::*;

    t_result    r_ent [2];
    t_result    n_ent [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [1:0] cnt_after_pop;

    always_comb begin
        n_ent         = r_ent;
        cnt_after_pop = r_cnt - {1'b0, i_pop};
        if (i_pop) begin
            n_ent[0] = r_ent[1];
        end
        case (cnt_after_pop)
            2'd0: begin
                if (i_push_cnt != 2'd0) begin
                    n_ent[0] = i_push0;
                end
                if (i_push_cnt == 2'd2) begin
                    n_ent[1] = i_push1;
                end
            end
            2'd1: begin
                if (i_push_cnt != 2'd0) begin
                    n_ent[1] = i_push0;
                end
            end
            default: begin
            end
        endcase
        n_cnt = cnt_after_pop + i_push_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_cnt  = r_cnt;
    assign o_head = r_ent[0];

endmodule

// File: hdl/scancode_set1_to_ascii_core.sv
// Flow: a scan code is held in the input register, then decoded into the two-entry
//   result queue, whose head drives the output port.
// The input takes one scan code per cycle while the queue has room for its results;
//   a lock key occupies the output for two transfers.
// Reset (i_rst_n low, synchronous): modifiers, locks and snapshot cleared,
//   input stage and result queue emptied.
module scancode_set1_to_ascii_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_scan_code,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_target,
    output logic [7:0] o_value,
    output logic       o_last
);
    import scs1_pkg::*;

    // input stage
    logic       r_s1_valid;
    logic       n_s1_valid;
    logic [7:0] r_s1_code;

    // keyboard state: held modifiers, locks, modifier snapshot
    t_kbd_state r_st;

    t_dec_out   dec;
    t_result    head;
    logic [1:0] q_cnt;
    logic [1:0] q_free;
    logic       in_xfer;
    logic       out_xfer;
    logic       s1_adv;
    logic [1:0] push_cnt;

    scs1_decode u_decode (
        .i_code (r_s1_code),
        .i_st   (r_st),
        .o_dec  (dec)
    );

    // Space left in the queue this cycle counts the entry leaving by an
    // output transfer, so a one-result stream moves every cycle even when
    // the queue holds one entry.
    assign out_xfer = o_valid && i_ready;
    assign q_free   = 2'd2 - q_cnt + {1'b0, out_xfer};

    // The held code retires once all its results fit; zero-result codes
    // (breaks, modifiers, ctrl-masked keys) always retire at once.
    assign s1_adv   = r_s1_valid && (dec.nres <= q_free);
    assign push_cnt = s1_adv ? dec.nres : 2'd0;

    assign o_ready  = !r_s1_valid || s1_adv;
    assign in_xfer  = i_valid && o_ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_xfer) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_st       <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (s1_adv) begin
                r_st <= dec.st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_code <= i_scan_code;
        end
    end

    scs1_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push0    (dec.res0),
        .i_push1    (dec.res1),
        .i_pop      (out_xfer),
        .o_cnt      (q_cnt),
        .o_head     (head)
    );

    assign o_valid  = (q_cnt != 2'd0);
    assign o_target = head.target;
    assign o_value  = head.value;
    assign o_last   = head.last;

`ifndef SYNTH
    // queue never overfills
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_cnt != 2'd3)
        else $error("result queue count out of range");

    // a code that cannot retire holds its place
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_code))
        else $error("input stage lost a stalled code");

    // console characters are always the single, final result of their code
    a_char_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_target == TGT_CONSOLE) |-> o_last)
        else $error("console character not marked last");

    // the only non-final result is the set-LEDs command
    a_cmd_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> (o_target == TGT_KEYBOARD) && (o_value == SET_LEDS_CMD))
        else $error("unexpected non-final result");

    // a lock key leaves a result pending after its retire
    a_lock_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && (dec.nres == 2'd2) |=> o_valid)
        else $error("lock key produced no output");
`endif

endmodule
